>>> rtl/sgps_pkg.sv
// ----------------------------------------------------------------------------
// sgps_pkg
// Shared types and constants for the scalar gain point smoother.
// ----------------------------------------------------------------------------
package sgps_pkg;

  // Field widths
  localparam int COORD_W    = 24;   // Q8.16 coordinate
  localparam int LEVEL_W    = 16;   // integer intensity
  localparam int REG_W      = 32;   // Q16.16 registers
  localparam int FRAC_W     = 16;   // fraction bits of Q16.16
  localparam int CFG_ADDR_W = 2;

  // Beat layout of tdata, lowest field first
  localparam int X_LSB     = 0;
  localparam int Y_LSB     = X_LSB + COORD_W;
  localparam int Z_LSB     = Y_LSB + COORD_W;
  localparam int LEVEL_LSB = Z_LSB + COORD_W;
  localparam int TDATA_W   = LEVEL_LSB + LEVEL_W;

  // Register reset values
  localparam logic [REG_W-1:0] MEAS_GAIN_RST = 32'd65536;    // 1.0
  localparam logic [REG_W-1:0] NOISE_VAR_RST = 32'd131072;   // 2.0
  localparam logic [REG_W-1:0] INIT_VAR_RST  = 32'd6553600;  // 100.0

  // Intensity written on every updated point
  localparam logic [LEVEL_W-1:0] UPDATED_LEVEL = 16'd50;

  // Coordinate saturation limits
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MEAS_GAIN = 2'd0,
    REG_NOISE_VAR = 2'd1,
    REG_INIT_VAR  = 2'd2
  } sgps_reg_t;

  // What happens to one point
  typedef enum logic [1:0] {
    MODE_LOAD,    // first unheld frame: copy raw point
    MODE_UPDATE,  // later unheld frame: filter toward raw point
    MODE_HOLD,    // held frame: return stored point
    MODE_DROP     // beyond store capacity
  } sgps_mode_t;

  // One stored / emitted point
  typedef struct packed {
    logic [LEVEL_W-1:0]        level;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } sgps_point_t;

  // Control from the sequencer to the merge stage
  typedef struct packed {
    logic       load;   // capture a result beat once the output register can take it
    sgps_mode_t mode;
    logic       last;
  } sgps_ctl_t;

endpackage

>>> rtl/scalar_gain_point_smoother.sv
// ----------------------------------------------------------------------------
// scalar_gain_point_smoother
// Per-point scalar Kalman smoother over frames of 3D points with a shared
// variance and gain. Three coordinate lanes, a gain unit and a merge stage.
//
//   channel  dir  handshake           payload
//   in_      in   tvalid/tready       tdata: pos_x, pos_y, pos_z, point_level
//                                     tlast: frame_end, tuser: hold
//   out_     out  tvalid/tready       tdata: est_x, est_y, est_z, est_level
//                                     tlast: out_last, tuser: overflow
//   cfg_     in   we                  addr: register index, wdata: value
//
// One point at a time. Load, held and dropped points go straight to the
// output register; a filtered point first runs the five-stage lane pipeline.
// The first point of a filtered frame also waits for the gain unit and
// its 48-step divider.
// Reset is synchronous and clears control state; the point store is not
// cleared. A stalled out_ side holds the finished beat and stops the
// sequencer only when the next beat is ready to go out.
// ----------------------------------------------------------------------------
module scalar_gain_point_smoother import sgps_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input beats
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // pos_x, pos_y, pos_z, point_level
  input  logic                  in_tlast,   // frame_end
  input  logic                  in_tuser,   // hold
  // result beats
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // est_x, est_y, est_z, est_level
  output logic                  out_tlast,  // out_last
  output logic                  out_tuser,  // overflow
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_GAIN, ST_START, ST_WAIT, ST_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  pidx_r, pidx_nxt;
  logic              held_r, held_nxt;
  logic              primed_r, primed_nxt;
  sgps_mode_t        mode_r;
  logic              last_r;
  logic [IDX_W-1:0]  aidx_r;
  sgps_point_t       raw_r;
  logic [REG_W-1:0]  meas_gain_r, noise_var_r;

  logic              accept, first, held_now, drop_now, need_gain;
  sgps_mode_t        mode_now;
  sgps_point_t       raw_pt, stored_pt, wb_pt;
  logic [$bits(sgps_point_t)-1:0] ram_rdata;
  logic              ram_we, var_load;
  logic              gain_done, can_load, lane_start;
  logic [REG_W-1:0]  gain;
  logic [2:0]        lane_done;
  logic signed [COORD_W-1:0] lane_x, lane_y, lane_z;
  sgps_ctl_t         ctl;

  // Input beat fields
  assign raw_pt.x     = in_tdata[X_LSB +: COORD_W];
  assign raw_pt.y     = in_tdata[Y_LSB +: COORD_W];
  assign raw_pt.z     = in_tdata[Z_LSB +: COORD_W];
  assign raw_pt.level = in_tdata[LEVEL_LSB +: LEVEL_W];

  // Classify the incoming point
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign first     = (pidx_r == '0);
  assign held_now  = first ? in_tuser : held_r;
  assign drop_now  = (pidx_r >= CNT_MAX);
  assign need_gain = first && !in_tuser && primed_r;

  always_comb begin
    if (drop_now) begin
      mode_now = MODE_DROP;
    end else if (held_now) begin
      mode_now = MODE_HOLD;
    end else if (primed_r) begin
      mode_now = MODE_UPDATE;
    end else begin
      mode_now = MODE_LOAD;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    pidx_nxt   = pidx_r;
    held_nxt   = held_r;
    primed_nxt = primed_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          held_nxt = held_now;
          if (in_tlast) begin
            pidx_nxt = '0;
          end else if (!drop_now) begin
            pidx_nxt = pidx_r + 1'b1;
          end
          if (in_tlast && !held_now) begin
            primed_nxt = 1'b1;
          end
          if (need_gain) begin
            state_nxt = ST_GAIN;
          end else if (mode_now == MODE_UPDATE) begin
            state_nxt = ST_START;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_GAIN: begin
        if (gain_done) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (&lane_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (can_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= mode_now;
      last_r <= in_tlast;
      aidx_r <= pidx_r[IDX_W-1:0];
      raw_r  <= raw_pt;
    end
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pidx_r      <= '0;
      held_r      <= 1'b0;
      primed_r    <= 1'b0;
      meas_gain_r <= MEAS_GAIN_RST;
      noise_var_r <= NOISE_VAR_RST;
    end else begin
      state_r  <= state_nxt;
      pidx_r   <= pidx_nxt;
      held_r   <= held_nxt;
      primed_r <= primed_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_MEAS_GAIN: meas_gain_r <= cfg_wdata;
          REG_NOISE_VAR: noise_var_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // init_var only matters until the store is primed
  assign var_load = cfg_we && (cfg_addr == REG_INIT_VAR) && !primed_r;

  // Point store
  assign ram_we    = (state_r == ST_OUT) && can_load &&
                     ((mode_r == MODE_LOAD) || (mode_r == MODE_UPDATE));
  assign stored_pt = sgps_point_t'(ram_rdata);

  sgps_ram #(
    .WIDTH ($bits(sgps_point_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (aidx_r),
    .wdata (wb_pt),
    .re    (accept),
    .raddr (pidx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Gain and variance
  sgps_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept && need_gain),
    .var_load  (var_load),
    .var_value (cfg_wdata),
    .meas_gain (meas_gain_r),
    .noise_var (noise_var_r),
    .done      (gain_done),
    .gain      (gain)
  );

  // Coordinate lanes
  assign lane_start = (state_r == ST_START);

  sgps_lane u_lane_x (
    .clk (clk), .rst_n (rst_n), .start (lane_start),
    .est (stored_pt.x), .raw (raw_r.x),
    .meas_gain (meas_gain_r), .gain (gain),
    .done (lane_done[0]), .result (lane_x)
  );

  sgps_lane u_lane_y (
    .clk (clk), .rst_n (rst_n), .start (lane_start),
    .est (stored_pt.y), .raw (raw_r.y),
    .meas_gain (meas_gain_r), .gain (gain),
    .done (lane_done[1]), .result (lane_y)
  );

  sgps_lane u_lane_z (
    .clk (clk), .rst_n (rst_n), .start (lane_start),
    .est (stored_pt.z), .raw (raw_r.z),
    .meas_gain (meas_gain_r), .gain (gain),
    .done (lane_done[2]), .result (lane_z)
  );

  // Merge and output register
  assign ctl.load = (state_r == ST_OUT);
  assign ctl.mode = mode_r;
  assign ctl.last = last_r;

  sgps_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .raw_pt     (raw_r),
    .stored_pt  (stored_pt),
    .lane_x     (lane_x),
    .lane_y     (lane_y),
    .lane_z     (lane_z),
    .can_load   (can_load),
    .wb_pt      (wb_pt),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Checks
  a_pidx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pidx_r <= CNT_MAX)
    else $error("point index past store capacity");

  a_primed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag cleared outside reset");

  a_gain_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    gain_done |-> (state_r == ST_GAIN))
    else $error("gain unit finished while sequencer not waiting");

  a_lane_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> ((state_r == ST_WAIT) && (&lane_done)))
    else $error("lanes out of step or finished unexpectedly");

  a_store_write_mode: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((mode_r == MODE_LOAD) || (mode_r == MODE_UPDATE)))
    else $error("store written for a held or dropped point");

endmodule

>>> rtl/sgps_ram.sv
// ----------------------------------------------------------------------------
// sgps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sgps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sgps_lane.sv
// ----------------------------------------------------------------------------
// sgps_lane
// One coordinate lane: est + K*(raw - H*est), truncating toward zero,
// saturated to Q8.16. Five register stages; stages 1, 3 and 4 each multiply.
// ----------------------------------------------------------------------------
module sgps_lane import sgps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] est,
  input  logic signed [COORD_W-1:0] raw,
  input  logic [REG_W-1:0]          meas_gain,
  input  logic [REG_W-1:0]          gain,
  output logic                      done,
  output logic signed [COORD_W-1:0] result
);

  localparam int M1_W  = COORD_W + REG_W;   // |est| * H
  localparam int T_W   = M1_W - FRAC_W;     // H*est magnitude
  localparam int D_W   = T_W + 2;           // signed difference
  localparam int HI_W  = T_W - FRAC_W;      // upper slice of |diff|
  localparam int PL_W  = FRAC_W + REG_W;    // low partial product
  localparam int PH_W  = HI_W + REG_W;      // high partial product
  localparam int ACC_W = PH_W + 1;
  localparam int SUM_W = ACC_W + 2;

  logic [4:0]                v_r;
  logic signed [COORD_W-1:0] est_r, raw_r;
  logic                      est_neg_r, d_neg_r;
  logic [M1_W-1:0]           m1_r;
  logic [T_W-1:0]            dmag_r;
  logic [PL_W-1:0]           pl_r;
  logic [HI_W-1:0]           dhi_r;
  logic [PH_W-1:0]           ph_r;
  logic signed [COORD_W-1:0] res_r;

  logic [COORD_W-1:0]        est_mag;
  logic [M1_W-1:0]           m1_nxt;
  logic [T_W-1:0]            t1;
  logic signed [D_W-1:0]     t1_s, diff, diff_abs;
  logic [PL_W-1:0]           pl_nxt;
  logic [PH_W-1:0]           ph_nxt;
  logic [ACC_W-1:0]          mag;
  logic signed [SUM_W-1:0]   corr, sum;
  logic signed [COORD_W-1:0] res_nxt;

  // Stage 1: |est| * H
  assign est_mag = est[COORD_W-1] ? COORD_W'(-est) : COORD_W'(est);
  assign m1_nxt  = M1_W'(est_mag) * M1_W'(meas_gain);

  // Stage 2: diff = raw - H*est, split into sign and magnitude
  assign t1       = m1_r[M1_W-1:FRAC_W];
  assign t1_s     = est_neg_r ? -$signed(D_W'(t1)) : $signed(D_W'(t1));
  assign diff     = D_W'(raw_r) - t1_s;
  assign diff_abs = diff[D_W-1] ? -diff : diff;

  // Stages 3 and 4: |diff| * K in two partial products
  assign pl_nxt = PL_W'(dmag_r[FRAC_W-1:0]) * PL_W'(gain);
  assign ph_nxt = PH_W'(dhi_r) * PH_W'(gain);

  // Stage 5: recombine, restore sign, add to estimate, saturate
  assign mag  = ACC_W'(ph_r) + ACC_W'(pl_r[PL_W-1:FRAC_W]);
  assign corr = d_neg_r ? -$signed(SUM_W'(mag)) : $signed(SUM_W'(mag));
  assign sum  = SUM_W'(est_r) + corr;

  always_comb begin
    if (sum > SUM_W'(COORD_MAX)) begin
      res_nxt = COORD_MAX;
    end else if (sum < SUM_W'(COORD_MIN)) begin
      res_nxt = COORD_MIN;
    end else begin
      res_nxt = sum[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      est_r     <= est;
      raw_r     <= raw;
      est_neg_r <= est[COORD_W-1];
      m1_r      <= m1_nxt;
    end
    if (v_r[0]) begin
      d_neg_r <= diff[D_W-1];
      dmag_r  <= diff_abs[T_W-1:0];
    end
    if (v_r[1]) begin
      pl_r  <= pl_nxt;
      dhi_r <= dmag_r[T_W-1:FRAC_W];
    end
    if (v_r[2]) begin
      ph_r <= ph_nxt;
    end
    if (v_r[3]) begin
      res_r <= res_nxt;
    end
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], start};
    end
  end

  assign done   = v_r[4];
  assign result = res_r;

endmodule

>>> rtl/sgps_gain.sv
// ----------------------------------------------------------------------------
// sgps_gain
// Gain and variance update, run once per filtered frame. One shared
// 32x32 multiplier and a restoring divider that yields one quotient bit
// per cycle: K = P*H*2^16 / (H*P*H + R), then P *= (1 - K*H).
// ----------------------------------------------------------------------------
module sgps_gain import sgps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             var_load,    // init_var write before priming
  input  logic [REG_W-1:0] var_value,
  input  logic [REG_W-1:0] meas_gain,
  input  logic [REG_W-1:0] noise_var,
  output logic             done,
  output logic [REG_W-1:0] gain
);

  localparam int PROD_W  = 2 * REG_W;
  localparam int NUM_W   = REG_W + FRAC_W;   // ph << 16
  localparam int DEN_W   = REG_W + 1;
  localparam int CNT_W   = $clog2(NUM_W);
  localparam int FACT_W  = FRAC_W + 1;
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(NUM_W - 1);
  localparam logic [FACT_W-1:0] ONE_Q16  = FACT_W'(1) << FRAC_W;

  typedef enum logic [3:0] {
    G_IDLE, G_MPH, G_MHPH, G_DEN, G_DIV, G_GAIN, G_MKH, G_MVAR, G_WVAR
  } gstate_t;

  gstate_t             state_r, state_nxt;
  logic [REG_W-1:0]    var_r, var_nxt;
  logic [REG_W-1:0]    gain_r, gain_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [REG_W-1:0]    ph_r, ph_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]    num_r, num_nxt;
  logic [NUM_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [REG_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [REG_W-1:0]    prod_sat;
  logic [DEN_W:0]      trial;
  logic                fits;
  logic [FACT_W-1:0]   factor;

  // Shared multiplier
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Q16.16 product shifted down and clamped to 32 bits
  assign prod_sat = (|prod_r[PROD_W-1:REG_W+FRAC_W]) ? '1
                                                     : prod_r[REG_W+FRAC_W-1:FRAC_W];

  // Divider step
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= (DEN_W+1)'(den_r);

  // 1 - K*H, clamped at zero
  assign factor = (|prod_r[PROD_W-1:REG_W]) ? '0
                                            : ONE_Q16 - FACT_W'(prod_r[REG_W-1:FRAC_W]);

  always_comb begin
    state_nxt = state_r;
    var_nxt   = var_r;
    gain_nxt  = gain_r;
    prod_nxt  = prod_r;
    ph_nxt    = ph_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    num_nxt   = num_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    mul_a     = var_r;
    mul_b     = meas_gain;
    case (state_r)
      G_IDLE: begin
        if (var_load) begin
          var_nxt = var_value;
        end
        if (start) begin
          state_nxt = G_MPH;
        end
      end
      G_MPH: begin
        prod_nxt  = mul_p;                 // P*H
        state_nxt = G_MHPH;
      end
      G_MHPH: begin
        ph_nxt    = prod_sat;
        mul_a     = prod_sat;
        prod_nxt  = mul_p;                 // (P*H)*H
        state_nxt = G_DEN;
      end
      G_DEN: begin
        den_nxt   = DEN_W'(prod_sat) + DEN_W'(noise_var);
        rem_nxt   = '0;
        num_nxt   = {ph_r, {FRAC_W{1'b0}}};
        quo_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = G_DIV;
      end
      G_DIV: begin
        rem_nxt = fits ? DEN_W'(trial - (DEN_W+1)'(den_r)) : trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], fits};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = G_GAIN;
        end
      end
      G_GAIN: begin
        // zero denominator: full gain unless the numerator is zero too
        if (den_r == '0) begin
          gain_nxt = (ph_r != '0) ? '1 : '0;
        end else if (|quo_r[NUM_W-1:REG_W]) begin
          gain_nxt = '1;
        end else begin
          gain_nxt = quo_r[REG_W-1:0];
        end
        state_nxt = G_MKH;
      end
      G_MKH: begin
        mul_a     = gain_r;
        prod_nxt  = mul_p;                 // K*H
        state_nxt = G_MVAR;
      end
      G_MVAR: begin
        mul_b     = REG_W'(factor);
        prod_nxt  = mul_p;                 // P*(1-K*H)
        state_nxt = G_WVAR;
      end
      G_WVAR: begin
        var_nxt   = prod_r[REG_W+FRAC_W-1:FRAC_W];
        state_nxt = G_IDLE;
      end
      default: begin
        state_nxt = G_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    ph_r   <= ph_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      state_r <= G_IDLE;
      var_r   <= INIT_VAR_RST;
      gain_r  <= '0;
    end else begin
      state_r <= state_nxt;
      var_r   <= var_nxt;
      gain_r  <= gain_nxt;
    end
  end

  assign done = (state_r == G_WVAR);
  assign gain = gain_r;

endmodule

>>> rtl/sgps_merge.sv
// ----------------------------------------------------------------------------
// sgps_merge
// Joins the lane results with the stored or raw point, forms the
// write-back point and holds the result beat until the sink takes it.
// ----------------------------------------------------------------------------
module sgps_merge import sgps_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sgps_ctl_t                 ctl,
  input  sgps_point_t               raw_pt,
  input  sgps_point_t               stored_pt,
  input  logic signed [COORD_W-1:0] lane_x,
  input  logic signed [COORD_W-1:0] lane_y,
  input  logic signed [COORD_W-1:0] lane_z,
  output logic                      can_load,
  output sgps_point_t               wb_pt,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [TDATA_W-1:0]        out_tdata,
  output logic                      out_tlast,
  output logic                      out_tuser
);

  sgps_point_t pt_r;
  logic        valid_r, last_r, ovf_r;
  logic        ovf;

  // Pick the point for this beat
  always_comb begin
    wb_pt = '0;
    ovf   = 1'b0;
    case (ctl.mode)
      MODE_LOAD: begin
        wb_pt = raw_pt;
      end
      MODE_UPDATE: begin
        wb_pt.x     = lane_x;
        wb_pt.y     = lane_y;
        wb_pt.z     = lane_z;
        wb_pt.level = UPDATED_LEVEL;
      end
      MODE_HOLD: begin
        wb_pt = stored_pt;
      end
      default: begin
        ovf = 1'b1;
      end
    endcase
  end

  assign can_load = !valid_r || out_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.load && can_load) begin
      pt_r   <= wb_pt;
      last_r <= ctl.last;
      ovf_r  <= ovf;
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load && can_load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {pt_r.level, pt_r.z, pt_r.y, pt_r.x};
  assign out_tlast  = last_r;
  assign out_tuser  = ovf_r;

endmodule
